### rtl/ssco_pkg.sv
package ssco_pkg;

	// pipeline depth, input register through output register
	localparam int NUM_STAGES = 14;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam int DRIVE_W = 24;
	localparam int DEFF_W  = 25;   // effective drive, up to 2x drive
	localparam int SPREAD_W = 17;
	localparam int BIAS_W  = 24;
	localparam int LEVEL_W = 24;
	localparam int MIX_W   = 17;

	// soft-region datapath widths
	localparam int V23_W = 28;
	localparam int Q_W   = 31;
	localparam int QD_W  = 30;
	localparam int U_W   = 32;
	localparam int A_W   = 27;
	localparam int M1_W  = 59;
	localparam int M2_W  = 28;
	localparam int M3_W  = 27;
	localparam int F_W   = 60;
	localparam int S_W   = 37;
	localparam int SLO_W = 18;
	localparam int P0_W  = 42;
	localparam int P1_W  = 44;
	localparam int PR_W  = 63;

	localparam logic [31:0]       RECIP3  = 32'hAAAA_AAAB;  // ceil(2^33 / 3)
	localparam logic [MIX_W-1:0]  ONE_Q16 = 17'h1_0000;
	localparam logic [Q_W-1:0]    T_SPLIT = 31'd12582912;   // 1.5 in Q.23
	localparam logic [U_W-1:0]    ONE_Q23 = 32'h0080_0000;

	localparam logic              STEREO_MODE_RST = 1'b1;
	localparam logic [DRIVE_W-1:0]  DRIVE_RST  = 24'd65536;
	localparam logic [SPREAD_W-1:0] SPREAD_RST = 17'd0;
	localparam logic [BIAS_W-1:0]   BIAS_RST   = 24'd1048576;
	localparam logic [LEVEL_W-1:0]  LEVEL_RST  = 24'd1048576;
	localparam logic [MIX_W-1:0]    MIX_RST    = 17'd65536;
	localparam logic [DEFF_W-1:0]   DEFF_RST   = 25'd65536;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STEREO_MODE = 3'd0,
		REG_DRIVE       = 3'd1,
		REG_SPREAD      = 3'd2,
		REG_BIAS        = 3'd3,
		REG_LEVEL       = 3'd4,
		REG_MIX         = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [BIAS_W-1:0]  bias;
		logic [LEVEL_W-1:0] level;
		logic [MIX_W-1:0]   mix_sat;
	} shape_cfg_t;

endpackage

### rtl/stereo_soft_clip_overdrive_core.sv
// Stereo cubic soft-clip overdrive, no state between frames.
//
// Input channel: one stereo frame (left_in, right_in, block_end) per transfer,
// transfer when in_valid is high and in_stall is low. Output channel: the
// processed frame on left_out / right_out with block_end_out copied through,
// transfer when out_valid is high and out_stall is low.
// Configuration: cfg_we writes cfg_data into the register picked by cfg_index
// (0 stereo_mode, 1 drive, 2 spread, 3 bias, 4 level, 5 mix); other indexes
// are ignored. Write only while no frame is in flight.
//
// A frame passes through every pipeline stage, from the input register to the
// output register. Throughput is one frame per cycle: every stage advances
// each cycle unless the output stalls. A stalled output holds its frame;
// stages behind it keep filling empty slots and in_stall rises only when
// every stage holds a frame and out_stall is high.
// Reset empties the pipeline and loads the register defaults
// (stereo, unity drive and level, bias 1.0, fully wet, no spread).
module stereo_soft_clip_overdrive_core #(
	parameter int SAMPLE_WIDTH = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]    left_in,
	input  logic signed [SAMPLE_WIDTH-1:0]    right_in,
	input  logic                              block_end,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [SAMPLE_WIDTH-1:0]    left_out,
	output logic signed [SAMPLE_WIDTH-1:0]    right_out,
	output logic                              block_end_out,
	input  logic                              cfg_we,
	input  logic [ssco_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ssco_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic                               stereo_mode;
	logic [ssco_pkg::DEFF_W-1:0]        drive_left;
	logic [ssco_pkg::DEFF_W-1:0]        drive_right;
	ssco_pkg::shape_cfg_t               shape_cfg;
	logic [ssco_pkg::NUM_STAGES-1:0]    en;

	ssco_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.stereo_mode (stereo_mode),
		.drive_left  (drive_left),
		.drive_right (drive_right),
		.shape_cfg   (shape_cfg)
	);

	ssco_pipe u_pipe (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.block_end     (block_end),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.block_end_out (block_end_out),
		.en            (en)
	);

	ssco_shaper #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_left (
		.clk       (clk),
		.en        (en),
		.bypass    (1'b0),
		.drive_eff (drive_left),
		.cfg       (shape_cfg),
		.x_in      (left_in),
		.y_out     (left_out)
	);

	// mono mode: right channel passes through untouched
	ssco_shaper #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_right (
		.clk       (clk),
		.en        (en),
		.bypass    (!stereo_mode),
		.drive_eff (drive_right),
		.cfg       (shape_cfg),
		.x_in      (right_in),
		.y_out     (right_out)
	);

endmodule

### rtl/ssco_cfg.sv
module ssco_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ssco_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ssco_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                              stereo_mode,
	output logic [ssco_pkg::DEFF_W-1:0]       drive_left,
	output logic [ssco_pkg::DEFF_W-1:0]       drive_right,
	output ssco_pkg::shape_cfg_t              shape_cfg
);

	logic                               stereo_mode_q;
	logic [ssco_pkg::DRIVE_W-1:0]       drive_q;
	logic [ssco_pkg::SPREAD_W-1:0]      spread_q;
	logic [ssco_pkg::BIAS_W-1:0]        bias_q;
	logic [ssco_pkg::LEVEL_W-1:0]       level_q;
	logic [ssco_pkg::MIX_W-1:0]         mix_q;
	logic [ssco_pkg::DEFF_W-1:0]        drive_left_q;
	logic [ssco_pkg::DEFF_W-1:0]        drive_right_q;
	logic [ssco_pkg::MIX_W-1:0]         mix_sat_q;

	logic [ssco_pkg::SPREAD_W-1:0]      sp_sat;
	logic [ssco_pkg::SPREAD_W-1:0]      mul_l;
	logic [ssco_pkg::SPREAD_W:0]        mul_r;
	logic [40:0]                        prod_l;
	logic [41:0]                        prod_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stereo_mode_q <= ssco_pkg::STEREO_MODE_RST;
			drive_q       <= ssco_pkg::DRIVE_RST;
			spread_q      <= ssco_pkg::SPREAD_RST;
			bias_q        <= ssco_pkg::BIAS_RST;
			level_q       <= ssco_pkg::LEVEL_RST;
			mix_q         <= ssco_pkg::MIX_RST;
		end else if (cfg_we) begin
			case (ssco_pkg::cfg_reg_t'(cfg_index))
				ssco_pkg::REG_STEREO_MODE: stereo_mode_q <= cfg_data[0];
				ssco_pkg::REG_DRIVE:       drive_q       <= cfg_data;
				ssco_pkg::REG_SPREAD:      spread_q      <= cfg_data[ssco_pkg::SPREAD_W-1:0];
				ssco_pkg::REG_BIAS:        bias_q        <= cfg_data;
				ssco_pkg::REG_LEVEL:       level_q       <= cfg_data;
				ssco_pkg::REG_MIX:         mix_q         <= cfg_data[ssco_pkg::MIX_W-1:0];
				default: ;
			endcase
		end
	end

	// spread above 1.0 acts as 1.0
	always_comb begin
		sp_sat = (spread_q > ssco_pkg::ONE_Q16) ? ssco_pkg::ONE_Q16 : spread_q;
		mul_l  = ssco_pkg::ONE_Q16 - sp_sat;
		mul_r  = {1'b0, ssco_pkg::ONE_Q16} + {1'b0, sp_sat};
		prod_l = drive_q * mul_l;
		prod_r = drive_q * mul_r;
	end

	// channel drives settle the cycle after a write, before any item reaches the multiplier
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_left_q  <= ssco_pkg::DEFF_RST;
			drive_right_q <= ssco_pkg::DEFF_RST;
			mix_sat_q     <= ssco_pkg::MIX_RST;
		end else begin
			drive_left_q  <= stereo_mode_q ? {1'b0, prod_l[39:16]} : {1'b0, drive_q};
			drive_right_q <= prod_r[40:16];
			mix_sat_q     <= (mix_q > ssco_pkg::ONE_Q16) ? ssco_pkg::ONE_Q16 : mix_q;
		end
	end

	assign stereo_mode       = stereo_mode_q;
	assign drive_left        = drive_left_q;
	assign drive_right       = drive_right_q;
	assign shape_cfg.bias    = bias_q;
	assign shape_cfg.level   = level_q;
	assign shape_cfg.mix_sat = mix_sat_q;

endmodule

### rtl/ssco_pipe.sv
module ssco_pipe (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              block_end,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              block_end_out,
	output logic [ssco_pkg::NUM_STAGES-1:0]   en
);

	localparam int N = ssco_pkg::NUM_STAGES;

	logic [N-1:0] vld_q;
	logic [N-1:0] be_q;

	// a stage loads unless it and every stage downstream of it hold a frame while the output stalls
	for (genvar i = 0; i < N; i++) begin : g_en
		assign en[i] = !((&vld_q[N-1:i]) && out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) vld_q[0] <= in_valid;
			for (int i = 1; i < N; i++) begin
				if (en[i]) vld_q[i] <= vld_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) be_q[0] <= block_end;
		for (int i = 1; i < N; i++) begin
			if (en[i]) be_q[i] <= be_q[i-1];
		end
	end

	assign in_stall      = !en[0];
	assign out_valid     = vld_q[N-1];
	assign block_end_out = be_q[N-1];

endmodule

### rtl/ssco_shaper.sv
module ssco_shaper #(
	parameter int SAMPLE_WIDTH = 24
) (
	input  logic                              clk,
	input  logic [ssco_pkg::NUM_STAGES-1:0]   en,
	input  logic                              bypass,
	input  logic [ssco_pkg::DEFF_W-1:0]       drive_eff,
	input  ssco_pkg::shape_cfg_t              cfg,
	input  logic signed [SAMPLE_WIDTH-1:0]    x_in,
	output logic signed [SAMPLE_WIDTH-1:0]    y_out
);

	localparam int W      = SAMPLE_WIDTH;
	localparam int VW     = W + ssco_pkg::DEFF_W;
	localparam int V23_SH = W - 8;
	localparam int LIM_SH = W - 5;
	localparam int LIM_W  = ssco_pkg::BIAS_W + LIM_SH;
	localparam int WET_SH = 44 - W;
	localparam int MX_W   = W + 19;
	localparam int PR_W   = ssco_pkg::PR_W;

	localparam logic signed [PR_W-1:0] WET_MAX = PR_W'(1) << (W - 1);
	localparam logic signed [PR_W-1:0] WET_MIN = -WET_MAX;
	localparam logic signed [MX_W:0]   OUT_MAX = ((MX_W + 1)'(1) <<< (W - 1)) - (MX_W + 1)'(1);
	localparam logic signed [MX_W:0]   OUT_MIN = -((MX_W + 1)'(1) <<< (W - 1));

	// sample carried alongside
	logic signed [W-1:0] x_s1, x_s2, x_s3, x_s4, x_s5, x_s6, x_s7;
	logic signed [W-1:0] x_s8, x_s9, x_s10, x_s11, x_s12, x_s13;

	logic signed [VW-1:0]                 v_s2;
	logic                                 hard_s3, hard_s4, hard_s5, hard_s6;
	logic                                 hard_s7, hard_s8, hard_s9;
	logic                                 neg_s3, neg_s4, neg_s5, neg_s6, neg_s7, neg_s8, neg_s9;
	logic signed [ssco_pkg::V23_W-1:0]    v23_s3, v23_s4, v23_s5;
	logic [ssco_pkg::Q_W-1:0]             q_s4, q_s5;
	logic [ssco_pkg::QD_W-1:0]            qd_s5;
	logic                                 sneg_s6, sneg_s7, sneg_s8, sneg_s9;
	logic [ssco_pkg::A_W-1:0]             a_s6;
	logic [ssco_pkg::U_W-1:0]             u_s6;
	logic [1:0]                           r_s6;
	logic [ssco_pkg::M1_W-1:0]            m1_s7, m1_s8;
	logic [ssco_pkg::M2_W-1:0]            m2_s7;
	logic [ssco_pkg::M3_W-1:0]            m3_s8;
	logic [ssco_pkg::F_W-1:0]             f_s9;
	logic signed [ssco_pkg::S_W-1:0]      s_s10;
	logic [ssco_pkg::P0_W-1:0]            p0_s11;
	logic signed [ssco_pkg::P1_W-1:0]     p1_s11;
	logic signed [W:0]                    wet_s12;
	logic signed [MX_W-1:0]               pw_s13, px_s13;
	logic signed [W-1:0]                  y_s14;

	// stage 2: drive gain
	logic signed [VW:0] v_full;
	always_comb v_full = x_s1 * $signed({1'b0, drive_eff});

	// stage 3: clamp test and rescale to Q.23
	logic signed [VW-1:0] lim;
	logic signed [VW-1:0] v_sh;
	logic                 hard_c;
	always_comb begin
		lim    = $signed({{(VW - LIM_W){1'b0}}, cfg.bias, {LIM_SH{1'b0}}});
		hard_c = (v_s2 > lim) || (v_s2 < -lim);
		v_sh   = v_s2 >>> V23_SH;
	end

	// stage 4: square
	logic signed [2*ssco_pkg::V23_W-1:0] sq;
	always_comb sq = v23_s3 * v23_s3;

	// stage 5: q / 3 by reciprocal
	logic [ssco_pkg::Q_W+31:0] qm;
	always_comb qm = q_s4 * ssco_pkg::RECIP3;

	// stage 6: |t| = 3*u + r with t = 3 - 2q, so (v23 * t) / 3 splits into a*u + a*r/3
	logic [1:0]                    three_qd, qr;
	logic                          t_neg;
	logic [ssco_pkg::U_W-1:0]      two_qd;
	logic [ssco_pkg::U_W-1:0]      u_c;
	logic [1:0]                    r_c;
	logic [ssco_pkg::V23_W-1:0]    v23_abs;
	always_comb begin
		three_qd = qd_s5[1:0] + {qd_s5[0], 1'b0};
		qr       = q_s5[1:0] - three_qd;
		t_neg    = q_s5 > ssco_pkg::T_SPLIT;
		two_qd   = {1'b0, qd_s5, 1'b0};
		v23_abs  = v23_s5[ssco_pkg::V23_W-1] ? ssco_pkg::V23_W'(-v23_s5) : v23_s5;
		if (!t_neg) begin
			u_c = ssco_pkg::ONE_Q23 - two_qd - {30'd0, qr};
			r_c = qr;
		end else begin
			case (qr)
				2'd0: begin
					u_c = two_qd - ssco_pkg::ONE_Q23;
					r_c = 2'd0;
				end
				2'd1: begin
					u_c = two_qd - ssco_pkg::ONE_Q23;
					r_c = 2'd2;
				end
				2'd2: begin
					u_c = two_qd - ssco_pkg::ONE_Q23 + 32'd1;
					r_c = 2'd1;
				end
				default: begin
					u_c = '0;
					r_c = 2'd0;
				end
			endcase
		end
	end

	// stage 7: partial products
	logic [ssco_pkg::M1_W-1:0] m1_c;
	logic [ssco_pkg::M2_W-1:0] m2_c;
	always_comb begin
		m1_c = a_s6 * u_s6;
		case (r_s6)
			2'd1:    m2_c = {1'b0, a_s6};
			2'd2:    m2_c = {a_s6, 1'b0};
			default: m2_c = '0;
		endcase
	end

	// stage 8: remainder part / 3
	logic [ssco_pkg::M2_W+31:0] m3_full;
	always_comb m3_full = m2_s7 * ssco_pkg::RECIP3;

	// stage 10: sign, floor to Q.23, clamp region select
	logic signed [ssco_pkg::F_W:0]  f_pos, f_sgn, f_sh;
	logic signed [ssco_pkg::S_W-1:0] s_hard;
	logic signed [ssco_pkg::S_W-1:0] s_c;
	always_comb begin
		f_pos  = {1'b0, f_s9};
		f_sgn  = sneg_s9 ? -f_pos : f_pos;
		f_sh   = f_sgn >>> 23;
		s_hard = {10'd0, cfg.bias, 3'd0};
		if (hard_s9) s_c = neg_s9 ? -s_hard : s_hard;
		else         s_c = f_sh[ssco_pkg::S_W-1:0];
	end

	// stage 11: level, split into two partial products
	logic [ssco_pkg::P0_W-1:0]        p0_c;
	logic signed [ssco_pkg::P1_W-1:0] p1_c;
	always_comb begin
		p0_c = s_s10[ssco_pkg::SLO_W-1:0] * cfg.level;
		p1_c = $signed(s_s10[ssco_pkg::S_W-1:ssco_pkg::SLO_W]) * $signed({1'b0, cfg.level});
	end

	// stage 12: recombine, scale, clamp to +-1.0
	logic signed [PR_W-1:0] prod, wsh;
	logic signed [W:0]      wet_c;
	always_comb begin
		prod = $signed({p1_s11[ssco_pkg::P1_W-1], p1_s11, {ssco_pkg::SLO_W{1'b0}}})
			+ $signed({{(PR_W - ssco_pkg::P0_W){1'b0}}, p0_s11});
		wsh  = prod >>> WET_SH;
		if (wsh > WET_MAX)      wet_c = WET_MAX[W:0];
		else if (wsh < WET_MIN) wet_c = WET_MIN[W:0];
		else                    wet_c = wsh[W:0];
	end

	// stage 13: wet/dry weights
	logic [ssco_pkg::MIX_W-1:0] dry_w;
	logic signed [MX_W-1:0]     pw_c, px_c;
	always_comb begin
		dry_w = ssco_pkg::ONE_Q16 - cfg.mix_sat;
		pw_c  = wet_s12 * $signed({1'b0, cfg.mix_sat});
		px_c  = x_s12 * $signed({1'b0, dry_w});
	end

	// stage 14: blend and saturate, or pass the dry sample through in bypass
	logic signed [MX_W:0] sum, sum_sh;
	logic signed [W-1:0]  y_c;
	always_comb begin
		sum    = {pw_s13[MX_W-1], pw_s13} + {px_s13[MX_W-1], px_s13};
		sum_sh = sum >>> 16;
		if (bypass)                 y_c = x_s13;
		else if (sum_sh > OUT_MAX)  y_c = OUT_MAX[W-1:0];
		else if (sum_sh < OUT_MIN)  y_c = OUT_MIN[W-1:0];
		else                        y_c = sum_sh[W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			x_s1 <= x_in;
		end
		if (en[1]) begin
			x_s2 <= x_s1;
			v_s2 <= v_full[VW-1:0];
		end
		if (en[2]) begin
			x_s3    <= x_s2;
			hard_s3 <= hard_c;
			neg_s3  <= v_s2[VW-1];
			v23_s3  <= v_sh[ssco_pkg::V23_W-1:0];
		end
		if (en[3]) begin
			x_s4    <= x_s3;
			hard_s4 <= hard_s3;
			neg_s4  <= neg_s3;
			v23_s4  <= v23_s3;
			q_s4    <= sq[ssco_pkg::Q_W+22:23];
		end
		if (en[4]) begin
			x_s5    <= x_s4;
			hard_s5 <= hard_s4;
			neg_s5  <= neg_s4;
			v23_s5  <= v23_s4;
			q_s5    <= q_s4;
			qd_s5   <= qm[ssco_pkg::QD_W+32:33];
		end
		if (en[5]) begin
			x_s6    <= x_s5;
			hard_s6 <= hard_s5;
			neg_s6  <= neg_s5;
			sneg_s6 <= v23_s5[ssco_pkg::V23_W-1] ^ t_neg;
			a_s6    <= v23_abs[ssco_pkg::A_W-1:0];
			u_s6    <= u_c;
			r_s6    <= r_c;
		end
		if (en[6]) begin
			x_s7    <= x_s6;
			hard_s7 <= hard_s6;
			neg_s7  <= neg_s6;
			sneg_s7 <= sneg_s6;
			m1_s7   <= m1_c;
			m2_s7   <= m2_c;
		end
		if (en[7]) begin
			x_s8    <= x_s7;
			hard_s8 <= hard_s7;
			neg_s8  <= neg_s7;
			sneg_s8 <= sneg_s7;
			m1_s8   <= m1_s7;
			m3_s8   <= m3_full[ssco_pkg::M2_W+31:33];
		end
		if (en[8]) begin
			x_s9    <= x_s8;
			hard_s9 <= hard_s8;
			neg_s9  <= neg_s8;
			sneg_s9 <= sneg_s8;
			f_s9    <= {1'b0, m1_s8} + {{(ssco_pkg::F_W - ssco_pkg::M3_W){1'b0}}, m3_s8};
		end
		if (en[9]) begin
			x_s10 <= x_s9;
			s_s10 <= s_c;
		end
		if (en[10]) begin
			x_s11  <= x_s10;
			p0_s11 <= p0_c;
			p1_s11 <= p1_c;
		end
		if (en[11]) begin
			x_s12   <= x_s11;
			wet_s12 <= wet_c;
		end
		if (en[12]) begin
			x_s13  <= x_s12;
			pw_s13 <= pw_c;
			px_s13 <= px_c;
		end
		if (en[13]) begin
			y_s14 <= y_c;
		end
	end

	assign y_out = y_s14;

endmodule

### rtl/ssco_checker.sv
module ssco_checker #(
	parameter int SAMPLE_WIDTH = 24
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic signed [SAMPLE_WIDTH-1:0]    left_out,
	input logic signed [SAMPLE_WIDTH-1:0]    right_out,
	input logic                              block_end_out
);

	localparam int N   = ssco_pkg::NUM_STAGES;
	localparam int QC_W = $clog2(N + 1);

	// cycles since the last input transfer with the receiver never stalling
	logic [QC_W-1:0] quiet_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_q <= '0;
		end else if ((in_valid && !in_stall) || out_stall) begin
			quiet_q <= '0;
		end else if (quiet_q != QC_W'(N)) begin
			quiet_q <= quiet_q + 1'b1;
		end
	end

	a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while the receiver takes results");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result waiting");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(left_out) && $stable(right_out)
			&& $stable(block_end_out))
		else $error("stalled result changed");

	a_pipe_drains: assert property (@(posedge clk) disable iff (!arst_n)
		quiet_q == QC_W'(N) |-> !out_valid)
		else $error("result appeared with no frame in flight");

endmodule

bind stereo_soft_clip_overdrive_core ssco_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_ssco_checker (.*);
